// File: rtl/core/b2dd_pkg.sv
// Package for the binary to decimal digit stream block.
// Holds shared constants, the front state type and the digit count helper.
// No dependencies.
package b2dd_pkg;

    // Default width of the binary value
    localparam int VALUE_WIDTH_DEF = 32;

    // Input bits taken into the converter per cycle
    localparam int BITS_PER_STEP = 4;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // ASCII code of the character zero
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // Front state machine
    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_CONV,
        FRONT_PUSH
    } front_state_t;

    // Decimal digits needed for a w-bit unsigned value (log10(2) ~ 0.30103)
    function automatic int num_digits(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

endpackage

// File: rtl/core/b2dd_front.sv
// Front end: accepts a binary word and converts it to packed BCD,
// four bits per cycle (shift and add-3), then pushes it to the queue.
// Depends on b2dd_pkg.
module b2dd_front #(
    parameter int VALUE_WIDTH = b2dd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                s_tvalid,
    output logic                                                s_tready,
    input  logic [VALUE_WIDTH-1:0]                              value,
    output logic                                                push_valid,
    input  logic                                                push_full,
    output logic [4*b2dd_pkg::num_digits(VALUE_WIDTH)-1:0]      push_bcd,
    output logic [$clog2(b2dd_pkg::num_digits(VALUE_WIDTH))-1:0] push_idx
);
    import b2dd_pkg::*;

    localparam int NDIG  = num_digits(VALUE_WIDTH);
    localparam int BW    = 4 * NDIG;
    localparam int IW    = $clog2(NDIG);
    localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PADW  = STEPS * BITS_PER_STEP;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    front_state_t    state_reg, state_next;
    logic [PADW-1:0] bin_reg, bin_next;
    logic [BW-1:0]   bcd_reg, bcd_next;
    logic [CW-1:0]   step_reg, step_next;
    logic [PADW-1:0] bin_step;
    logic [BW-1:0]   bcd_step;
    logic [IW-1:0]   top_idx;
    logic            last_step;

    // One conversion step: adjust and shift in BITS_PER_STEP bits
    always_comb begin
        bcd_step = bcd_reg;
        bin_step = bin_reg;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (bcd_step[4*d +: 4] >= 4'd5) begin
                    bcd_step[4*d +: 4] = bcd_step[4*d +: 4] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BW-2:0], bin_step[PADW-1]};
            bin_step = {bin_step[PADW-2:0], 1'b0};
        end
    end

    // Locate the most significant non-zero digit
    always_comb begin
        top_idx = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (bcd_reg[4*d +: 4] != 4'd0) begin
                top_idx = IW'(d);
            end
        end
    end

    assign last_step = (step_reg == CW'(STEPS - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FRONT_IDLE: begin
                if (s_tvalid) begin
                    state_next = FRONT_CONV;
                end
            end
            FRONT_CONV: begin
                if (last_step) begin
                    state_next = FRONT_PUSH;
                end
            end
            FRONT_PUSH: begin
                if (!push_full) begin
                    state_next = FRONT_IDLE;
                end
            end
            default: state_next = FRONT_IDLE;
        endcase
    end

    // Outputs and datapath next values
    always_comb begin
        s_tready   = 1'b0;
        push_valid = 1'b0;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        unique case (state_reg)
            FRONT_IDLE: begin
                s_tready  = 1'b1;
                bin_next  = PADW'(value);
                bcd_next  = '0;
                step_next = '0;
            end
            FRONT_CONV: begin
                bin_next  = bin_step;
                bcd_next  = bcd_step;
                step_next = step_reg + CW'(1);
            end
            FRONT_PUSH: begin
                push_valid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign push_bcd = bcd_reg;
    assign push_idx = top_idx;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FRONT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold datapath words
    always_ff @(posedge aclk) begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        step_reg <= step_next;
    end

endmodule

// File: rtl/core/b2dd_fifo.sv
// Short queue of converted words between front and back.
// Register-based, one write and one read per cycle.
// Depends on b2dd_pkg.
module b2dd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import b2dd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Store a word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

endmodule

// File: rtl/core/b2dd_back.sv
// Back end: takes a BCD word from the queue and sends its digits as
// ASCII, most significant first, one per cycle unless m_tready is low. Depends on b2dd_pkg.
module b2dd_back #(
    parameter int NDIG = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  logic [4*NDIG-1:0]       q_bcd,
    input  logic [$clog2(NDIG)-1:0] q_idx,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [5:0]              digit_char,
    output logic                    last_digit
);
    import b2dd_pkg::*;

    localparam int IW = $clog2(NDIG);

    logic              busy_reg;
    logic [4*NDIG-1:0] bcd_reg;
    logic [IW-1:0]     idx_reg;
    logic [3:0]        digit;
    logic              sent;

    assign digit      = bcd_reg[4*idx_reg +: 4];
    assign digit_char = ASCII_ZERO + {2'b00, digit};
    assign last_digit = (idx_reg == '0);
    assign m_tvalid   = busy_reg;
    assign sent       = busy_reg && m_tready;
    assign q_pop      = !q_empty && (!busy_reg || (sent && last_digit));

    // Busy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
        end else if (sent && last_digit) begin
            busy_reg <= 1'b0;
        end
    end

    // Load a new word or step down to the next digit
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            bcd_reg <= q_bcd;
            idx_reg <= q_idx;
        end else if (sent && !last_digit) begin
            idx_reg <= idx_reg - IW'(1);
        end
    end

endmodule

// File: rtl/core/binary_to_decimal_digits.sv
// Binary to decimal ASCII digit stream, top level.
// Instantiates b2dd_front, b2dd_fifo and b2dd_back; depends on b2dd_pkg.
//
// Usage:
//   s_ channel: one unsigned binary word per handshake (s_tdata).
//   m_ channel: one ASCII digit per word, most significant first, without
//   leading zeros; m_tlast marks the final digit. Zero gives a single '0'.
//   Order: after acceptance the front converts the word, then pushes it into
//   the queue, holding while the queue is full; the back pops it into its
//   output register, from which the first digit is shown.
//   Throughput: the front's pace is set by the four-bit-per-cycle converter;
//   it takes no new input word until it has converted and pushed the last one.
//   The back sends one digit per cycle while m_tready is high, so long numbers
//   are bounded by the output side. A two-entry queue lets front and back run apart.
//   Stall: while m_tready is low the current digit holds; the queue fills,
//   then the front holds its word and s_tready stays low.
//   Reset (aresetn low, synchronous) empties the queue and drops any word
//   in flight.
module binary_to_decimal_digits #(
    parameter int VALUE_WIDTH = b2dd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,   // [VALUE_WIDTH-1:0] value
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                                 m_tlast
);
    import b2dd_pkg::*;

    localparam int NDIG = num_digits(VALUE_WIDTH);
    localparam int BW   = 4 * NDIG;
    localparam int IW   = $clog2(NDIG);
    localparam int EW   = BW + IW;

    logic          push_valid, push_full;
    logic [BW-1:0] push_bcd;
    logic [IW-1:0] push_idx;
    logic [EW-1:0] q_data;
    logic          q_pop, q_empty;
    logic [5:0]    digit_char;

    // Accept and convert
    b2dd_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .value      (s_tdata[VALUE_WIDTH-1:0]),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_bcd   (push_bcd),
        .push_idx   (push_idx)
    );

    // Decouple front from back
    b2dd_fifo #(
        .WIDTH (EW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data ({push_idx, push_bcd}),
        .full      (push_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // Serialise digits
    b2dd_back #(
        .NDIG (NDIG)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_bcd      (q_data[BW-1:0]),
        .q_idx      (q_data[EW-1:BW]),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .digit_char (digit_char),
        .last_digit (m_tlast)
    );

    assign m_tdata = {2'b00, digit_char};

endmodule

// File: tb/binary_to_decimal_digits_test.sv
// Testbench for binary_to_decimal_digits: drives 32-bit values and checks the
// ASCII digit words against an in-bench predictor. Depends on b2dd_pkg and the RTL.
`timescale 1ns / 1ps

module binary_to_decimal_digits_test;
    import b2dd_pkg::*;

    localparam int VALUE_WIDTH = 32;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [5:0] digit_char;
        logic       last_digit;
    } digit_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [5:0] digit_char, [7:6] zero
    logic        m_tlast;

    digit_word_t digits_due[$];
    digit_word_t head;
    int          errors;
    int          cycles;
    int          sender_idle_pct;
    int          sink_stall_pct;

    binary_to_decimal_digits #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Work out the decimal digits of one value, most significant first
    function automatic void queue_decimal_digits(input logic [31:0] value);
        logic [5:0]  rev[20];
        logic [31:0] v;
        int          n;
        digit_word_t w;
        v = value;
        n = 0;
        do begin
            rev[n] = ASCII_ZERO + 6'(v % 32'd10);
            n++;
            v = v / 32'd10;
        end while (v != 0);
        for (int i = n - 1; i >= 0; i--) begin
            w.digit_char = rev[i];
            w.last_digit = (i == 0);
            digits_due.push_back(w);
        end
    endfunction

    // Draw a value: full range, short numbers, edges of powers of ten, near maximum
    function automatic logic [31:0] pick_value();
        int          kind;
        int          e;
        logic [63:0] p;
        kind = $urandom_range(0, 5);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 9);
            2: return $urandom_range(0, 99999);
            3: begin
                e = $urandom_range(1, 9);
                p = 1;
                repeat (e) p = p * 10;
                return 32'(p) + 32'($urandom_range(0, 2)) - 32'd1;
            end
            4: return $urandom >> $urandom_range(0, 31);
            default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
        endcase
    endfunction

    // Send one word; called at a rising edge, returns at the edge of acceptance
    task automatic send_value(input logic [31:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        queue_decimal_digits(value);
    endtask

    // Hold off until every expected digit has arrived
    task automatic wait_for_drain();
        while (digits_due.size() != 0) @(posedge aclk);
    endtask

    // Zero, maximum, powers of ten and runs of nines, alternating bit patterns
    task automatic test_directed();
        logic [31:0] p;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
        p = 1;
        for (int i = 0; i < 10; i++) begin
            send_value(p);
            if (i > 0) send_value(p - 32'd1);
            p = p * 10;
        end
        s_tvalid <= 1'b0;
    endtask

    // Random values under a given idling mix
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        repeat (count) send_value(pick_value());
        s_tvalid <= 1'b0;
    endtask

    // Pause the sender until the block has fully drained, then resume
    task automatic test_pause_until_drained();
        sender_idle_pct = 0;
        sink_stall_pct  = 30;
        repeat (4) send_value(pick_value());
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_for_drain();
        repeat (4) send_value(pick_value());
        s_tvalid <= 1'b0;
    endtask

    // Stall the digit side at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Compare each accepted digit word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (digits_due.size() == 0) begin
                $error("unexpected digit word: digit_char %0d last_digit %0d",
                       m_tdata[5:0], m_tlast);
                errors++;
            end else begin
                head = digits_due.pop_front();
                if (m_tdata[5:0] !== head.digit_char) begin
                    $error("digit_char: expected %0d, got %0d", head.digit_char, m_tdata[5:0]);
                    errors++;
                end
                if (m_tlast !== head.last_digit) begin
                    $error("last_digit: expected %0d, got %0d", head.last_digit, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(90, 0, 0);
        test_pause_until_drained();
        test_random(90, 66, 0);
        test_random(90, 0, 66);
        test_random(70, 26, 26);

        @(posedge aclk);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (digits_due.size() != 0) begin
            $error("%0d digit words never arrived", digits_due.size());
        end
        if (errors == 0 && digits_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/b2dd_pkg.sv
rtl/core/b2dd_front.sv
rtl/core/b2dd_fifo.sv
rtl/core/b2dd_back.sv
rtl/core/binary_to_decimal_digits.sv
tb/binary_to_decimal_digits_test.sv
